// File: sv/fss_pkg.sv
package fss_pkg;

  // Field widths shared by the channel interfaces and the scorer.
  localparam int CH_W    = 8;
  localparam int LINE_W  = 16;
  localparam int SCORE_W = 8;
  localparam int POS_W   = 16;
  localparam int LEN_W   = 5;

  // Needle capacity and line counter limit.
  localparam int MAX_NEEDLE = 16;
  localparam int LINE_COUNT = 65536;
  localparam int NEEDLE_BYTES = 16;

  // Register indexes (byte address = 8 * index).
  localparam logic [1:0] REG_NEEDLE_LOW  = 2'd0;
  localparam logic [1:0] REG_NEEDLE_HIGH = 2'd1;
  localparam logic [1:0] REG_NEEDLE_LEN  = 2'd2;

  typedef logic [NEEDLE_BYTES-1:0][CH_W-1:0] needle_t;

  // ASCII upper to lower case.
  function automatic logic [CH_W-1:0] fold(input logic [CH_W-1:0] c);
    logic [CH_W-1:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

// File: sv/fss_in_if.sv
interface fss_in_if;
  logic                      valid;
  logic                      ready;
  logic [fss_pkg::CH_W-1:0]  ch;
  logic                      has_char;
  logic                      last_of_line;
  logic                      last_of_pane;

  modport source (output valid, ch, has_char, last_of_line, last_of_pane, input ready);
  modport sink   (input valid, ch, has_char, last_of_line, last_of_pane, output ready);
endinterface

// File: sv/fss_out_if.sv
interface fss_out_if;
  logic                         valid;
  logic                         ready;
  logic [fss_pkg::LINE_W-1:0]   line_number;
  logic [fss_pkg::SCORE_W-1:0]  line_score;
  logic [fss_pkg::LINE_W-1:0]   best_line;
  logic [fss_pkg::SCORE_W-1:0]  best_score;
  logic                         block_done;

  modport source (output valid, line_number, line_score, best_line, best_score, block_done,
                  input ready);
  modport sink   (input valid, line_number, line_score, best_line, best_score, block_done,
                  output ready);
endinterface

// File: sv/fuzzy_subsequence_line_scorer.sv
// Fuzzy subsequence line scorer. Text bytes enter on text_in, one request per
// byte, with end of line and end of block marks; every request that ends a
// line yields one result request on line_out carrying that line's score and
// the best line of the block so far (earliest line wins ties). Bytes are
// ASCII case-folded and matched greedily against a needle of up to 16 bytes
// set over the APB port (needle_bytes_low at 0x00, needle_bytes_high at 0x08,
// needle_length at 0x10; 64-bit data). The block takes one request per clock
// while results are taken: a byte is captured in an input register, the
// per-line match state is updated from it while it sits there, and a line
// result is registered in an output register when that byte moves on.
// The output register stalls the input register only when a result is held
// and not taken. Write the needle only while no line is in flight.
module fuzzy_subsequence_line_scorer (
  input  logic                       clk,
  input  logic                       rst,
  fss_in_if.sink                     text_in,
  fss_out_if.source                  line_out,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [4:0]                 paddr,
  input  logic [63:0]                pwdata,
  output logic [63:0]                prdata,
  output logic                       pready
);

  localparam logic [fss_pkg::LEN_W-1:0]   NEEDLE_CAP = fss_pkg::LEN_W'(fss_pkg::MAX_NEEDLE);
  localparam logic [fss_pkg::LINE_W-1:0]  LINE_LAST  = fss_pkg::LINE_W'(fss_pkg::LINE_COUNT - 1);
  localparam logic [fss_pkg::POS_W-1:0]   POS_LAST   = '1;

  // ---------------------------------------------------------------- config
  logic [63:0]                needle_low;
  logic [63:0]                needle_high;
  logic [fss_pkg::LEN_W-1:0]  needle_len;
  logic [1:0]                 reg_index;
  logic                       cfg_write;

  assign pready    = 1'b1;
  assign reg_index = paddr[4:3];
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      needle_low  <= '0;
      needle_high <= '0;
      needle_len  <= '0;
    end else if (cfg_write) begin
      case (reg_index)
        fss_pkg::REG_NEEDLE_LOW:  needle_low  <= pwdata;
        fss_pkg::REG_NEEDLE_HIGH: needle_high <= pwdata;
        fss_pkg::REG_NEEDLE_LEN:  needle_len  <= pwdata[fss_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      fss_pkg::REG_NEEDLE_LOW:  prdata = needle_low;
      fss_pkg::REG_NEEDLE_HIGH: prdata = needle_high;
      fss_pkg::REG_NEEDLE_LEN:  prdata = {{(64 - fss_pkg::LEN_W){1'b0}}, needle_len};
      default:                  prdata = '0;
    endcase
  end

  // ---------------------------------------------------------- input stage
  logic                       s1_valid;
  logic [fss_pkg::CH_W-1:0]   s1_ch;
  logic                       s1_has_char;
  logic                       s1_eol;
  logic                       s1_eop;
  logic                       s1_advance;

  // s1 moves on unless the output slot is full and stalled
  assign s1_advance    = s1_valid && (!line_out.valid || line_out.ready);
  assign text_in.ready = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (text_in.ready) begin
      s1_valid <= text_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text_in.valid && text_in.ready) begin
      s1_ch       <= text_in.ch;
      s1_has_char <= text_in.has_char;
      s1_eol      <= text_in.last_of_line;
      s1_eop      <= text_in.last_of_pane;
    end
  end

  // ------------------------------------------------------------ line state
  logic [fss_pkg::LEN_W-1:0]    needle_index, needle_index_next;
  logic [fss_pkg::LEN_W-1:0]    run_length, run_length_next;
  logic [fss_pkg::SCORE_W-1:0]  partial_score, partial_score_next;
  logic [fss_pkg::POS_W-1:0]    first_match_pos, first_match_pos_next;
  logic                         first_seen, first_seen_next;
  logic [fss_pkg::POS_W-1:0]    byte_position, byte_position_next;
  logic [fss_pkg::LINE_W-1:0]   line_counter, line_counter_next;
  logic [fss_pkg::SCORE_W-1:0]  best_score, best_score_next;
  logic [fss_pkg::LINE_W-1:0]   best_line, best_line_next;

  fss_pkg::needle_t             needle;
  logic [fss_pkg::LEN_W-1:0]    eff_len;
  logic [fss_pkg::CH_W-1:0]     needle_ch;
  logic                         active;
  logic                         match;
  logic [fss_pkg::SCORE_W:0]    sum_wide;
  logic [fss_pkg::POS_W-3:0]    penalty;
  logic [fss_pkg::SCORE_W-1:0]  score;

  assign needle  = {needle_high, needle_low};
  assign eff_len = (needle_len > NEEDLE_CAP) ? NEEDLE_CAP : needle_len;

  // index 16 and up reads as zero
  assign needle_ch = needle_index[fss_pkg::LEN_W-1] ? '0 :
                     fss_pkg::fold(needle[needle_index[fss_pkg::LEN_W-2:0]]);
  assign active    = s1_has_char && (needle_index < eff_len);
  assign match     = active && (fss_pkg::fold(s1_ch) == needle_ch);
  // partial + 1 + (run + 1), saturated below
  assign sum_wide  = {1'b0, partial_score} + (fss_pkg::SCORE_W + 1)'(run_length) +
                     (fss_pkg::SCORE_W + 1)'(2);

  always_comb begin
    needle_index_next    = needle_index;
    run_length_next      = run_length;
    partial_score_next   = partial_score;
    first_match_pos_next = first_match_pos;
    first_seen_next      = first_seen;
    byte_position_next   = byte_position;

    if (match) begin
      needle_index_next  = needle_index + 1'b1;
      run_length_next    = run_length + 1'b1;
      partial_score_next = sum_wide[fss_pkg::SCORE_W] ? '1 : sum_wide[fss_pkg::SCORE_W-1:0];
      if (!first_seen) begin
        first_seen_next      = 1'b1;
        first_match_pos_next = byte_position;
      end
    end else if (active) begin
      run_length_next = '0;
    end
    if (s1_has_char && byte_position != POS_LAST) begin
      byte_position_next = byte_position + 1'b1;
    end
  end

  // line score from the state after this byte
  assign penalty = first_match_pos_next[fss_pkg::POS_W-1:2];

  always_comb begin
    score = '0;
    if (eff_len != '0 && needle_index_next >= eff_len) begin
      score = partial_score_next;
      if (first_match_pos_next != '0) begin
        score = ((fss_pkg::POS_W - 2)'(partial_score_next) > penalty) ?
                partial_score_next - fss_pkg::SCORE_W'(penalty) : fss_pkg::SCORE_W'(1);
      end
      if (score == '0) begin
        score = fss_pkg::SCORE_W'(1);
      end
    end
  end

  always_comb begin
    best_score_next   = best_score;
    best_line_next    = best_line;
    line_counter_next = line_counter;
    if (score > best_score) begin
      best_score_next = score;
      best_line_next  = line_counter;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      needle_index    <= '0;
      run_length      <= '0;
      partial_score   <= '0;
      first_match_pos <= '0;
      first_seen      <= 1'b0;
      byte_position   <= '0;
      line_counter    <= '0;
      best_score      <= '0;
      best_line       <= '0;
    end else if (s1_advance) begin
      if (s1_eol) begin
        // line done: clear per-line state, roll counters
        needle_index    <= '0;
        run_length      <= '0;
        partial_score   <= '0;
        first_match_pos <= '0;
        first_seen      <= 1'b0;
        byte_position   <= '0;
        if (s1_eop) begin
          line_counter <= '0;
          best_score   <= '0;
          best_line    <= '0;
        end else begin
          best_score <= best_score_next;
          best_line  <= best_line_next;
          if (line_counter < LINE_LAST) begin
            line_counter <= line_counter_next + 1'b1;
          end
        end
      end else begin
        needle_index    <= needle_index_next;
        run_length      <= run_length_next;
        partial_score   <= partial_score_next;
        first_match_pos <= first_match_pos_next;
        first_seen      <= first_seen_next;
        byte_position   <= byte_position_next;
      end
    end
  end

  // --------------------------------------------------------- output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      line_out.valid <= 1'b0;
    end else if (s1_advance) begin
      line_out.valid <= s1_eol;
    end else if (line_out.ready) begin
      line_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_eol) begin
      line_out.line_number <= line_counter;
      line_out.line_score  <= score;
      line_out.best_line   <= best_line_next;
      line_out.best_score  <= best_score_next;
      line_out.block_done  <= s1_eop;
    end
  end

  // ------------------------------------------------------------ assertions
  a_best_covers_line: assert property (@(posedge clk) disable iff (rst)
    line_out.valid |-> line_out.best_score >= line_out.line_score)
    else $error("best score below line score");

  a_best_not_ahead: assert property (@(posedge clk) disable iff (rst)
    line_out.valid |-> line_out.best_line <= line_out.line_number)
    else $error("best line after current line");

  a_stall_holds_s1: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_advance |=> s1_valid && $stable(s1_ch) && $stable(s1_eol))
    else $error("stalled input register changed");

endmodule

// File: sim/tb_fuzzy_subsequence_line_scorer.sv
`timescale 1ns / 1ps

module tb_fuzzy_subsequence_line_scorer;

  localparam int IDLE_PCT      = 31;       // idle share on both sides, percent
  localparam int HOLD_CYCLES   = 200;      // long receiver hold-off
  localparam int SETTLE_CYCLES = 4;        // two-stage pipe plus margin
  localparam int LIMIT_CYCLES  = 50000;    // watchdog

  // Kinds of needle content and of generated lines.
  typedef enum int {NDL_LETTERS, NDL_ANY_BYTE, NDL_ALL_ONES} needle_kind_t;
  typedef enum int {LINE_NOISE, LINE_FULL, LINE_PARTIAL} line_shape_t;

  typedef struct packed {
    logic [fss_pkg::LINE_W-1:0]  line_number;
    logic [fss_pkg::SCORE_W-1:0] line_score;
    logic [fss_pkg::LINE_W-1:0]  best_line;
    logic [fss_pkg::SCORE_W-1:0] best_score;
    logic                        block_done;
  } line_result_t;

  // Tracks the per-line match state and the best line of the block, and holds
  // the line results still owed by the block.
  class line_score_tracker_t;
    logic [fss_pkg::CH_W-1:0]    needle_q [fss_pkg::NEEDLE_BYTES];
    logic [fss_pkg::LEN_W-1:0]   needle_len;
    logic [fss_pkg::LEN_W-1:0]   match_idx;
    logic [fss_pkg::LEN_W-1:0]   run_len;
    logic [fss_pkg::SCORE_W-1:0] partial;
    logic [fss_pkg::POS_W-1:0]   first_pos;
    logic                        seen;
    logic [fss_pkg::POS_W-1:0]   byte_pos;
    logic [fss_pkg::LINE_W-1:0]  line_idx;
    logic [fss_pkg::SCORE_W-1:0] best_sc;
    logic [fss_pkg::LINE_W-1:0]  best_ln;
    line_result_t                owed_lines[$];
    int unsigned                 mismatches;
    int unsigned                 lines_seen;
    int unsigned                 scored_lines;
    int unsigned                 blocks_seen;

    function new();
      foreach (needle_q[b]) needle_q[b] = '0;
      needle_len = '0;
      line_idx = '0;
      best_sc = '0;
      best_ln = '0;
      mismatches = 0;
      lines_seen = 0;
      scored_lines = 0;
      blocks_seen = 0;
      clear_line();
    endfunction

    function void clear_line();
      match_idx = '0;
      run_len = '0;
      partial = '0;
      first_pos = '0;
      seen = 1'b0;
      byte_pos = '0;
    endfunction

    function logic [fss_pkg::CH_W-1:0] lower_ascii(logic [fss_pkg::CH_W-1:0] c);
      if (c >= 8'h41 && c <= 8'h5A) begin
        return c + 8'h20;
      end
      return c;
    endfunction

    function void write_reg(logic [1:0] idx, logic [63:0] value);
      case (idx)
        fss_pkg::REG_NEEDLE_LOW: begin
          for (int b = 0; b < 8; b++) needle_q[b] = value[8*b +: 8];
        end
        fss_pkg::REG_NEEDLE_HIGH: begin
          for (int b = 0; b < 8; b++) needle_q[b+8] = value[8*b +: 8];
        end
        fss_pkg::REG_NEEDLE_LEN: begin
          needle_len = value[fss_pkg::LEN_W-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    function void note_request(logic [fss_pkg::CH_W-1:0] c, logic has, logic eol, logic eop);
      int n;
      int total;
      int pen;
      int score;
      line_result_t r;
      n = (int'(needle_len) > fss_pkg::MAX_NEEDLE) ? fss_pkg::MAX_NEEDLE : int'(needle_len);
      if (has) begin
        if (int'(match_idx) < n) begin
          if (lower_ascii(c) == lower_ascii(needle_q[match_idx[3:0]])) begin
            if (!seen) begin
              seen = 1'b1;
              first_pos = byte_pos;
            end
            run_len = run_len + 1'b1;
            total = int'(partial) + 1 + int'(run_len);
            partial = (total > 255) ? 8'hFF : fss_pkg::SCORE_W'(total);
            match_idx = match_idx + 1'b1;
          end else begin
            run_len = '0;
          end
        end
        if (byte_pos != 16'hFFFF) byte_pos = byte_pos + 1'b1;
      end
      if (!eol) return;

      score = 0;
      if (n != 0 && int'(match_idx) >= n) begin
        score = int'(partial);
        pen = int'(first_pos) / 4;
        if (first_pos != 0) score = (score > pen) ? score - pen : 1;
        if (score == 0) score = 1;
      end
      // strict compare: earliest line keeps a tie
      if (score > int'(best_sc)) begin
        best_sc = fss_pkg::SCORE_W'(score);
        best_ln = line_idx;
      end
      r.line_number = line_idx;
      r.line_score  = fss_pkg::SCORE_W'(score);
      r.best_line   = best_ln;
      r.best_score  = best_sc;
      r.block_done  = eop;
      owed_lines.push_back(r);

      clear_line();
      if (eop) begin
        line_idx = '0;
        best_sc = '0;
        best_ln = '0;
      end else if (int'(line_idx) < fss_pkg::LINE_COUNT - 1) begin
        line_idx = line_idx + 1'b1;
      end
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_line(line_result_t got);
      line_result_t want;
      if (owed_lines.size() == 0) begin
        $display("%0t: unexpected line result, expected none, actual line %0d score %0d",
                 $time, got.line_number, got.line_score);
        mismatches++;
        return;
      end
      want = owed_lines.pop_front();
      lines_seen++;
      if (want.line_score != 0) scored_lines++;
      if (want.block_done) blocks_seen++;
      compare_field("line_number", want.line_number, got.line_number);
      compare_field("line_score", want.line_score, got.line_score);
      compare_field("best_line", want.best_line, got.best_line);
      compare_field("best_score", want.best_score, got.best_score);
      compare_field("block_done", want.block_done, got.block_done);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  fss_in_if  text_if ();
  fss_out_if line_if ();

  fuzzy_subsequence_line_scorer DUT (
    .clk      (clk),
    .rst      (rst),
    .text_in  (text_if),
    .line_out (line_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  line_score_tracker_t tracker = new();

  // Needle as last programmed, kept here to build matching lines.
  logic [fss_pkg::CH_W-1:0]  cur_needle [fss_pkg::NEEDLE_BYTES];
  logic [fss_pkg::LEN_W-1:0] cur_len;

  bit          steady_flow;     // 1 = neither side idles
  bit          hold_request;    // asks the receiver for one long hold-off
  int          hold_left;
  int unsigned text_sent;
  int unsigned settings_done;
  int unsigned input_stalls;
  int unsigned cycle_count;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog.
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: run did not finish within %0d cycles", $time, LIMIT_CYCLES);
    $display("status: fail");
    $finish;
  end

  // Result side: check each accepted line result, then pick ready for the
  // next edge. The long hold-off is counted here, independent of the sender.
  initial begin
    line_result_t got;
    hold_left = 0;
    input_stalls = 0;
    line_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && line_if.valid && line_if.ready) begin
        got.line_number = line_if.line_number;
        got.line_score  = line_if.line_score;
        got.best_line   = line_if.best_line;
        got.best_score  = line_if.best_score;
        got.block_done  = line_if.block_done;
        tracker.check_line(got);
      end
      if (!rst && text_if.valid && !text_if.ready) input_stalls++;
      if (rst) begin
        line_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        line_if.ready <= 1'b0;
        hold_left--;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        line_if.ready <= 1'b0;
      end else if (steady_flow) begin
        line_if.ready <= 1'b1;
      end else begin
        line_if.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // One text request; returns at the edge that accepts it. Valid is only
  // dropped when an idle cycle is taken, so back-to-back requests keep it high.
  task automatic send_text(input logic [7:0] c, input logic has, input logic eol,
                           input logic eop);
    while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
      text_if.valid <= 1'b0;
      @(posedge clk);
    end
    text_if.valid        <= 1'b1;
    text_if.ch           <= c;
    text_if.has_char     <= has;
    text_if.last_of_line <= eol;
    text_if.last_of_pane <= eop;
    @(posedge clk);
    while (!text_if.ready) @(posedge clk);
    tracker.note_request(c, has, eol, eop);
    text_sent++;
  endtask

  // Sender stops and waits until every owed line result is in, then lets the
  // pipe settle so no byte is still in flight.
  task automatic wait_idle();
    text_if.valid <= 1'b0;
    while (tracker.owed_lines.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup, access, register taken at the access edge.
  task automatic apb_write(input logic [1:0] idx, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    tracker.write_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_needle(input logic [fss_pkg::LEN_W-1:0] len);
    logic [63:0] lo;
    logic [63:0] hi;
    wait_idle();
    for (int b = 0; b < 8; b++) begin
      lo[8*b +: 8] = cur_needle[b];
      hi[8*b +: 8] = cur_needle[b+8];
    end
    cur_len = len;
    apb_write(fss_pkg::REG_NEEDLE_LOW, lo);
    apb_write(fss_pkg::REG_NEEDLE_HIGH, hi);
    apb_write(fss_pkg::REG_NEEDLE_LEN, {59'd0, len});
    settings_done++;
  endtask

  task automatic pick_needle(input needle_kind_t kind, input logic [fss_pkg::LEN_W-1:0] len);
    logic [7:0] c;
    foreach (cur_needle[b]) begin
      case (kind)
        NDL_LETTERS: begin
          c = 8'h61 + 8'($urandom_range(25));
          if ($urandom_range(1) == 1) c = c - 8'h20;
        end
        NDL_ANY_BYTE: c = 8'($urandom_range(255));
        default:      c = 8'hFF;
      endcase
      cur_needle[b] = c;
    end
    set_needle(len);
  endtask

  function automatic int eff_len();
    return (int'(cur_len) > fss_pkg::MAX_NEEDLE) ? fss_pkg::MAX_NEEDLE : int'(cur_len);
  endfunction

  function automatic logic [7:0] vary_case(logic [7:0] c);
    if (c >= 8'h61 && c <= 8'h7A && $urandom_range(1) == 1) return c - 8'h20;
    if (c >= 8'h41 && c <= 8'h5A && $urandom_range(1) == 1) return c + 8'h20;
    return c;
  endfunction

  function automatic logic [7:0] junk_byte();
    int r;
    r = $urandom_range(9);
    if (r < 5) return 8'($urandom_range(255));
    if (r < 8 && eff_len() > 0)
      return vary_case(cur_needle[4'($urandom_range(eff_len() - 1))]);
    return vary_case(8'h61 + 8'($urandom_range(25)));
  endfunction

  // One line: the needle (or a prefix of it) spread among junk, or pure noise.
  // The line ends either on its last byte or on a separate empty request.
  task automatic send_line(input line_shape_t shape);
    logic [7:0] body[$];
    int   k;
    logic eop;
    logic tail_empty;
    if (shape != LINE_NOISE && eff_len() > 0) begin
      k = (shape == LINE_PARTIAL) ? $urandom_range(eff_len() - 1) : eff_len();
      for (int j = 0; j < k; j++) begin
        repeat ($urandom_range(2)) body.push_back(junk_byte());
        body.push_back(vary_case(cur_needle[j]));
      end
      repeat ($urandom_range(2)) body.push_back(junk_byte());
    end else begin
      repeat ($urandom_range(10)) body.push_back(junk_byte());
    end
    eop = ($urandom_range(7) == 0);
    tail_empty = (body.size() == 0) || ($urandom_range(3) == 0);
    foreach (body[i]) begin
      // stray empty request, pane mark random (must be ignored)
      if ($urandom_range(15) == 0)
        send_text(8'($urandom_range(255)), 1'b0, 1'b0, 1'($urandom_range(1)));
      if (!tail_empty && i == body.size() - 1)
        send_text(body[i], 1'b1, 1'b1, eop);
      else
        send_text(body[i], 1'b1, 1'b0, 1'($urandom_range(1)));
    end
    if (tail_empty) send_text(8'($urandom_range(255)), 1'b0, 1'b1, eop);
  endtask

  // Random lines, mostly well formed. With hold_at >= 0 the receiver holds off
  // once while a burst of one-byte lines keeps the input offered.
  task automatic run_phase(input int unsigned count, input int hold_at);
    int unsigned start;
    int          r;
    bit          held;
    start = text_sent;
    held = 1'b0;
    while (text_sent - start < count) begin
      if (hold_at >= 0 && !held && text_sent - start >= hold_at) begin
        held = 1'b1;
        hold_request = 1'b1;
        repeat (40) send_text(8'($urandom_range(255)), 1'b1, 1'b1, 1'b0);
      end
      r = $urandom_range(99);
      if (r < 70)      send_line(LINE_FULL);
      else if (r < 85) send_line(LINE_PARTIAL);
      else             send_line(LINE_NOISE);
    end
  endtask

  initial begin
    rst                  <= 1'b1;
    text_if.valid        <= 1'b0;
    text_if.ch           <= '0;
    text_if.has_char     <= 1'b0;
    text_if.last_of_line <= 1'b0;
    text_if.last_of_pane <= 1'b0;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    steady_flow  = 1'b0;
    hold_request = 1'b0;
    text_sent     = 0;
    settings_done = 0;
    cur_len = '0;
    foreach (cur_needle[b]) cur_needle[b] = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed ---
    // zero needle length straight out of reset: any line scores zero
    send_text(8'h61, 1'b1, 1'b1, 1'b0);

    // needle "AbC", mixed case in the register
    cur_needle[0] = 8'h41;
    cur_needle[1] = 8'h62;
    cur_needle[2] = 8'h43;
    set_needle(5'd3);
    send_text(8'h55, 1'b0, 1'b0, 1'b1);      // pane mark without line end: ignored
    send_text(8'h61, 1'b1, 1'b0, 1'b0);      // a
    send_text(8'h42, 1'b1, 1'b0, 1'b0);      // B
    send_text(8'h63, 1'b1, 1'b1, 1'b0);      // c, scored before the line closes
    send_text(8'h00, 1'b0, 1'b1, 1'b0);      // empty line
    // broken runs and fold edges: '@' and '[' sit just outside A..Z
    send_text(8'h78, 1'b1, 1'b0, 1'b0);      // x
    send_text(8'h40, 1'b1, 1'b0, 1'b0);      // @
    send_text(8'h41, 1'b1, 1'b0, 1'b0);      // A
    send_text(8'h5B, 1'b1, 1'b0, 1'b0);      // [
    send_text(8'h62, 1'b1, 1'b0, 1'b0);      // b
    send_text(8'h5A, 1'b1, 1'b0, 1'b0);      // Z
    send_text(8'h43, 1'b1, 1'b1, 1'b0);      // C
    send_text(8'h00, 1'b1, 1'b0, 1'b0);
    send_text(8'hFF, 1'b1, 1'b1, 1'b1);      // block end, counters clear
    // equal scores in a new block: the first line stays best
    send_text(8'h61, 1'b1, 1'b0, 1'b0);
    send_text(8'h62, 1'b1, 1'b0, 1'b0);
    send_text(8'h63, 1'b1, 1'b1, 1'b0);
    send_text(8'h41, 1'b1, 1'b0, 1'b0);
    send_text(8'h42, 1'b1, 1'b0, 1'b0);
    send_text(8'h43, 1'b1, 1'b1, 1'b1);

    // --- random phases over several needles ---
    pick_needle(NDL_LETTERS, 5'd1);
    run_phase(300, -1);
    pick_needle(NDL_LETTERS, 5'd5);
    run_phase(300, 150);
    pick_needle(NDL_ALL_ONES, 5'd16);      // widest needle, top score reachable
    run_phase(250, -1);
    pick_needle(NDL_ANY_BYTE, 5'd0);       // length zero with live needle bytes
    run_phase(200, -1);
    pick_needle(NDL_LETTERS, 5'd31);       // length above capacity saturates
    run_phase(300, -1);
    pick_needle(NDL_ANY_BYTE, 5'($urandom_range(2, 15)));
    run_phase(200, -1);

    // --- a long stretch with neither side idling ---
    steady_flow = 1'b1;
    run_phase(200, -1);
    steady_flow = 1'b0;
    run_phase(60, -1);

    wait_idle();
    $display("checked %0d line results (%0d scored, %0d block ends) from %0d text requests",
             tracker.lines_seen, tracker.scored_lines, tracker.blocks_seen, text_sent);
    $display("%0d needle settings; input back-pressure on %0d cycles; %0d mismatches",
             settings_done, input_stalls, tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
